### src/vcw_pkg.sv
package vcw_pkg;

  localparam int PING_DEPTH_DEF = 16;
  localparam int DIV_W = 64;
  localparam int DEN_W = 32;

  localparam logic [2:0] OP_INIT  = 3'd0;
  localparam logic [2:0] OP_PING  = 3'd1;
  localparam logic [2:0] OP_PONG  = 3'd2;
  localparam logic [2:0] OP_QUERY = 3'd3;
  localparam logic [2:0] OP_TICK  = 3'd4;

  localparam logic [22:0] WIN_INIT = 23'd16384;
  localparam logic [22:0] WIN_MIN  = 23'd4096;
  localparam logic [22:0] WIN_MAX  = 23'd4194304;
  localparam logic [22:0] WIN_STEP = 23'd4096;
  localparam logic [23:0] WIN_FAST = 24'd8192;
  localparam logic [31:0] WAIT_MAX = 32'd100;
  localparam logic [31:0] DIFF_BIG = 32'd100;
  localparam logic [31:0] DIFF_MID = 32'd50;
  localparam logic [31:0] DIFF_LOW = 32'd25;
  localparam logic [31:0] DIFF_TINY = 32'd5;

  typedef struct packed {
    logic [2:0]  operation;
    logic [31:0] now_ms;
    logic [31:0] sock_offset;
    logic [31:0] idle_ms;
  } vcw_in_t;

  typedef struct packed {
    logic        congested;
    logic [22:0] window_bytes;
    logic        ping_dropped;
  } vcw_out_t;

  typedef struct packed {
    logic [31:0] time_ms;
    logic [31:0] offset;
    logic [31:0] inflight;
  } vcw_ping_t;

  function automatic logic [22:0] win_clamp(input logic [DIV_W-1:0] w);
    logic [22:0] r;
    if (w < DIV_W'(WIN_MIN)) begin
      r = WIN_MIN;
    end else if (w > DIV_W'(WIN_MAX)) begin
      r = WIN_MAX;
    end else begin
      r = w[22:0];
    end
    return r;
  endfunction

endpackage

### src/vegas_congestion_window.sv
// Vegas-style congestion window controller. Pulse start with an operation on in_data while
// busy is low; exactly one result follows as a one-cycle out_valid strobe, which cannot be
// stalled, so sample it when it comes. Init, ping, query, tick without a ratio update and
// pong on an empty FIFO give their result from S_EXEC; a pong without queueing correction
// gives it from S_PONG, which follows S_EXEC. A pong whose ping exceeded the window,
// and a tick that rescales the window by base/min RTT, pass through the 32x32 multiplier and
// the shared bit-serial divider (64 quotient bits, one per cycle) and end in S_POST.
// The user writes fence_enabled via cfg_we/cfg_wdata only while the block is idle; this is
// not enforced. Ping records live in a PING_DEPTH-entry FIFO; no clearing pass is needed.
module vegas_congestion_window #(
  parameter int PING_DEPTH = vcw_pkg::PING_DEPTH_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  vcw_pkg::vcw_in_t  in_data,
  output logic              out_valid,
  output vcw_pkg::vcw_out_t out_data,
  input  logic              cfg_we,
  input  logic              cfg_wdata
);
  import vcw_pkg::*;

  localparam int CW = $clog2(PING_DEPTH + 1);

  typedef enum logic [2:0] {
    S_IDLE, S_EXEC, S_PONG, S_MUL, S_DIV, S_WAIT, S_POST
  } state_t;

  state_t      state_r;
  vcw_in_t     item_r;
  logic        fence_r;
  logic [22:0] cw_r;
  logic [31:0] acked_r;
  logic [31:0] sent_r;
  logic [31:0] base_r;
  logic [31:0] min_r;
  logic        seen_r;
  logic        running_r;
  logic [31:0] deadline_r;
  logic        out_valid_r;
  logic        cong_r;
  logic        drop_r;
  logic        mode_tick_r;
  logic [31:0] rtt_r;
  logic [31:0] mul_a_r;
  logic [31:0] mul_b_r;
  logic [31:0] div_den_r;
  logic [63:0] prod_r;

  logic          push;
  logic          pop;
  vcw_ping_t     push_data;
  vcw_ping_t     rd_data;
  logic [CW-1:0] count;
  logic          full;
  logic          div_done;
  logic [63:0]   quotient;

  logic [31:0] rtt_raw;
  logic [31:0] rtt_pong;
  logic [31:0] base_new;
  logic [31:0] wait_ms;
  logic [31:0] past;
  logic [31:0] diff;
  logic [31:0] lim_big;
  logic [31:0] lim_mid;
  logic [31:0] rtt_corr;
  logic [31:0] in_flight;

  assign full      = count == CW'(PING_DEPTH);
  assign in_flight = item_r.sock_offset - acked_r;
  assign push      = (state_r == S_EXEC) && (item_r.operation == OP_PING) && fence_r && !full;
  assign pop       = (state_r == S_EXEC) && (item_r.operation == OP_PONG) && (count != '0);
  assign push_data = '{time_ms: item_r.now_ms, offset: item_r.sock_offset,
                       inflight: in_flight};

  vcw_fifo #(.DEPTH(PING_DEPTH)) u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .rd_data   (rd_data),
    .count     (count)
  );

  vcw_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (state_r == S_DIV),
    .dividend (prod_r),
    .divisor  (div_den_r),
    .done     (div_done),
    .quotient (quotient)
  );

  always_comb begin
    rtt_raw  = item_r.now_ms - rd_data.time_ms;
    rtt_pong = (rtt_raw == '0) ? 32'd1 : rtt_raw;
    base_new = (rtt_pong < base_r) ? rtt_pong : base_r;
    wait_ms  = (base_r >= (WAIT_MAX >> 1)) ? WAIT_MAX : {base_r[30:0], 1'b0};
    past     = item_r.now_ms - deadline_r;
    diff     = min_r - base_r;
    lim_big  = (base_r < DIFF_BIG) ? base_r : DIFF_BIG;
    lim_mid  = ((base_r >> 1) < DIFF_MID) ? (base_r >> 1) : DIFF_MID;
    rtt_corr = (quotient < {32'd0, rtt_r}) ? rtt_r - quotient[31:0] : 32'd1;
    if (rtt_corr < base_r) begin
      rtt_corr = base_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      fence_r     <= 1'b0;
      cw_r        <= WIN_INIT;
      acked_r     <= '0;
      sent_r      <= '0;
      base_r      <= '1;
      min_r       <= '1;
      seen_r      <= 1'b0;
      running_r   <= 1'b0;
      deadline_r  <= '0;
      out_valid_r <= 1'b0;
      cong_r      <= 1'b0;
      drop_r      <= 1'b0;
      mode_tick_r <= 1'b0;
    end else begin
      out_valid_r <= 1'b0;
      if (cfg_we) begin
        fence_r <= cfg_wdata;
      end
      unique case (state_r)
        S_IDLE: begin
          if (start) begin
            item_r  <= in_data;
            cong_r  <= 1'b0;
            drop_r  <= 1'b0;
            state_r <= S_EXEC;
          end
        end
        S_EXEC: begin
          state_r     <= S_IDLE;
          out_valid_r <= 1'b1;
          case (item_r.operation)
            OP_INIT: begin
              acked_r <= item_r.sock_offset;
              cw_r    <= WIN_INIT;
            end
            OP_PING: begin
              if (fence_r && full) begin
                drop_r <= 1'b1;
              end else if (fence_r) begin
                sent_r <= item_r.sock_offset;
                if (!running_r) begin
                  deadline_r <= item_r.now_ms + wait_ms;
                  running_r  <= 1'b1;
                end
              end
            end
            OP_PONG: begin
              // hold the result until the entry has been read
              if (count != '0) begin
                state_r     <= S_PONG;
                out_valid_r <= 1'b0;
              end
            end
            OP_QUERY: begin
              if (!fence_r) begin
                cong_r <= 1'b0;
              end else if (sent_r == acked_r &&
                           {1'b0, item_r.idle_ms} > {base_r, 1'b0}) begin
                if (cw_r > WIN_INIT) begin
                  cw_r <= WIN_INIT;
                end
              end else if (in_flight < {9'd0, cw_r}) begin
                cong_r <= 1'b0;
              end else begin
                cong_r <= (count != CW'(1));
              end
            end
            OP_TICK: begin
              if (running_r && !past[31]) begin
                running_r <= 1'b0;
                if (seen_r) begin
                  seen_r <= 1'b0;
                  min_r  <= '1;
                  if (diff > lim_big) begin
                    if (min_r != '0) begin
                      mul_a_r     <= {9'd0, cw_r};
                      mul_b_r     <= base_r;
                      div_den_r   <= min_r;
                      mode_tick_r <= 1'b1;
                      state_r     <= S_MUL;
                      out_valid_r <= 1'b0;
                    end
                  end else if (diff > lim_mid) begin
                    cw_r <= (cw_r >= WIN_STEP) ? win_clamp(64'(cw_r - WIN_STEP))
                                               : WIN_MIN;
                  end else if (diff < DIFF_TINY) begin
                    cw_r <= win_clamp(64'({1'b0, cw_r} + WIN_FAST));
                  end else if (diff < DIFF_LOW) begin
                    cw_r <= win_clamp(64'({1'b0, cw_r} + {1'b0, WIN_STEP}));
                  end
                end
              end
            end
            default: begin
            end
          endcase
        end
        S_PONG: begin
          acked_r <= rd_data.offset;
          base_r  <= base_new;
          if (rd_data.inflight > {9'd0, cw_r}) begin
            seen_r      <= 1'b1;
            rtt_r       <= rtt_pong;
            mul_a_r     <= rd_data.inflight - {9'd0, cw_r};
            mul_b_r     <= base_new;
            div_den_r   <= {9'd0, cw_r};
            mode_tick_r <= 1'b0;
            state_r     <= S_MUL;
          end else begin
            if (rtt_pong < min_r) begin
              min_r <= rtt_pong;
            end
            state_r     <= S_IDLE;
            out_valid_r <= 1'b1;
          end
        end
        S_MUL: begin
          prod_r  <= mul_a_r * mul_b_r;
          state_r <= S_DIV;
        end
        S_DIV: begin
          state_r <= S_WAIT;
        end
        S_WAIT: begin
          if (div_done) begin
            state_r <= S_POST;
          end
        end
        S_POST: begin
          if (mode_tick_r) begin
            cw_r <= win_clamp(quotient);
          end else if (rtt_corr < min_r) begin
            min_r <= rtt_corr;
          end
          state_r     <= S_IDLE;
          out_valid_r <= 1'b1;
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign busy      = state_r != S_IDLE;
  assign out_valid = out_valid_r;
  assign out_data  = '{congested: cong_r, window_bytes: cw_r, ping_dropped: drop_r};

`ifndef NO_ASSERTIONS
  a_result_when_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy) else $error("result strobe while busy");

  a_accept_goes_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> (busy && !out_valid)) else $error("accepted item not taken up");

  a_window_bounds: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.window_bytes >= WIN_MIN && out_data.window_bytes <= WIN_MAX))
    else $error("window out of range");

  a_fifo_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count <= CW'(PING_DEPTH)) else $error("ping fifo overfilled");
`endif

endmodule

### src/vcw_div.sv
module vcw_div (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  input  logic [vcw_pkg::DIV_W-1:0]  dividend,
  input  logic [vcw_pkg::DEN_W-1:0]  divisor,
  output logic                       done,
  output logic [vcw_pkg::DIV_W-1:0]  quotient
);
  import vcw_pkg::*;

  localparam int CNT_W = $clog2(DIV_W);

  logic             busy_r;
  logic             done_r;
  logic [CNT_W-1:0] cnt_r;
  logic [DEN_W-1:0] rem_r;
  logic [DEN_W-1:0] den_r;
  logic [DIV_W-1:0] quo_r;
  logic [DEN_W:0]   shifted;
  logic             fits;
  logic [DEN_W:0]   diff;

  assign shifted = {rem_r, quo_r[DIV_W-1]};
  assign fits    = shifted >= {1'b0, den_r};
  assign diff    = shifted - {1'b0, den_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == CNT_W'(DIV_W - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // one quotient bit per cycle, restoring
  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= '0;
      den_r <= divisor;
      quo_r <= dividend;
    end else if (busy_r) begin
      rem_r <= fits ? diff[DEN_W-1:0] : shifted[DEN_W-1:0];
      quo_r <= {quo_r[DIV_W-2:0], fits};
    end
  end

  assign done     = done_r;
  assign quotient = quo_r;

endmodule

### src/vcw_fifo.sv
module vcw_fifo #(
  parameter int DEPTH = vcw_pkg::PING_DEPTH_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         push,
  input  vcw_pkg::vcw_ping_t           push_data,
  input  logic                         pop,
  output vcw_pkg::vcw_ping_t           rd_data,
  output logic [$clog2(DEPTH+1)-1:0]   count
);
  import vcw_pkg::*;

  localparam int IW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  vcw_ping_t     mem [DEPTH];
  vcw_ping_t     rd_data_r;
  logic [IW-1:0] head_r;
  logic [CW-1:0] count_r;
  logic [CW:0]   sum;
  logic [IW-1:0] tail;

  always_comb begin
    sum = {{(CW + 1 - IW){1'b0}}, head_r} + {1'b0, count_r};
    if (sum >= (CW + 1)'(DEPTH)) begin
      sum = sum - (CW + 1)'(DEPTH);
    end
    tail = sum[IW-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r  <= '0;
      count_r <= '0;
    end else if (push) begin
      count_r <= count_r + 1'b1;
    end else if (pop) begin
      count_r <= count_r - 1'b1;
      head_r  <= (head_r == IW'(DEPTH - 1)) ? '0 : head_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[tail] <= push_data;
    end
    if (pop) begin
      rd_data_r <= mem[head_r];
    end
  end

  assign rd_data = rd_data_r;
  assign count   = count_r;

endmodule
